// ===== rtl/core/imx_pkg.sv =====
// shared types, command codes and the source-to-enable map of the interrupt mux pair
package imx_pkg;

	localparam int WORD_BITS           = 32;
	localparam int TAB_MUXES           = 2;
	localparam int SOURCES_PER_MUX_DEF = 32;
	localparam int MUX_COUNT_DEF       = 2;

	// commands
	localparam logic [3:0] CMD_EVENT    = 4'd0;
	localparam logic [3:0] CMD_MASK     = 4'd1;
	localparam logic [3:0] CMD_UNMASK   = 4'd2;
	localparam logic [3:0] CMD_DISABLE  = 4'd3;
	localparam logic [3:0] CMD_W1C      = 4'd4;
	localparam logic [3:0] CMD_WR_EN    = 4'd5;
	localparam logic [3:0] CMD_READ     = 4'd6;
	localparam logic [3:0] CMD_DISPATCH = 4'd7;
	localparam logic [3:0] CMD_ACK      = 4'd8;

	// result codes
	localparam logic [1:0] RC_OK     = 2'd0;
	localparam logic [1:0] RC_UNUSED = 2'd1;
	localparam logic [1:0] RC_RSVD   = 2'd2;

	// map entry marks
	localparam logic [7:0] ENT_UNUSED = 8'hFF;
	localparam logic [7:0] ENT_RSVD   = 8'hFE;

	localparam logic [7:0] ENABLE_MAP [TAB_MUXES][WORD_BITS] = '{
		'{ENT_UNUSED, ENT_UNUSED, ENT_RSVD, 8'd3, ENT_UNUSED, 8'd5, ENT_RSVD, ENT_RSVD,
		  8'd7, ENT_RSVD, 8'd10, 8'd11, 8'd12, 8'd6, 8'd14, 8'd15,
		  ENT_UNUSED, ENT_UNUSED, ENT_UNUSED, 8'd19, 8'd20, 8'd21, 8'd22, 8'd28,
		  8'd24, ENT_UNUSED, 8'd26, 8'd27, ENT_UNUSED, 8'd29, ENT_UNUSED, ENT_UNUSED},
		'{ENT_UNUSED, ENT_RSVD, 8'd2, ENT_UNUSED, ENT_UNUSED, 8'd5, ENT_UNUSED, ENT_RSVD,
		  8'd8, ENT_RSVD, ENT_UNUSED, 8'd11, 8'd12, 8'd13, ENT_UNUSED, ENT_UNUSED,
		  ENT_UNUSED, ENT_UNUSED, ENT_UNUSED, 8'd19, 8'd20, ENT_RSVD, ENT_RSVD, ENT_RSVD,
		  ENT_RSVD, ENT_UNUSED, ENT_UNUSED, ENT_UNUSED, ENT_UNUSED, 8'd29, 8'd30, 8'd31}
	};

	typedef struct packed {
		logic [3:0]  command;
		logic        mux_select;
		logic [4:0]  source_bit;
		logic [31:0] write_data;
		logic [31:0] line_levels;
	} in_beat_t;

	typedef struct packed {
		logic [5:0]  source_number;
		logic        found;
		logic        last;
		logic [1:0]  result_code;
		logic [31:0] status_word;
		logic [31:0] enable_word;
		logic [31:0] stuck_mask;
		logic [1:0]  parent_irq;
	} out_beat_t;

	// sequencer to register bank
	typedef struct packed {
		logic     exec;
		in_beat_t item;
	} bank_req_t;

	// register bank to sequencer
	typedef struct packed {
		logic        present;
		logic [1:0]  code;
		logic [31:0] stuck;
		logic [31:0] live_sel;
		logic [31:0] status_word;
		logic [31:0] enable_word;
		logic [1:0]  parent_irq;
	} bank_rsp_t;

	function automatic logic [7:0] map_entry(input logic mux, input logic [4:0] bit_pos);
		map_entry = ENABLE_MAP[mux][bit_pos];
	endfunction

endpackage

// ===== rtl/core/imx_bank.sv =====
// status, enable and serviced registers of both muxes with their update unit
module imx_bank #(
	parameter int SOURCES_PER_MUX = imx_pkg::SOURCES_PER_MUX_DEF,
	parameter int MUX_COUNT       = imx_pkg::MUX_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  imx_pkg::bank_req_t req,
	output imx_pkg::bank_rsp_t rsp
);
	localparam int SCAN_BITS = (SOURCES_PER_MUX < imx_pkg::WORD_BITS) ?
		SOURCES_PER_MUX : imx_pkg::WORD_BITS;

	logic [31:0] status_q   [imx_pkg::TAB_MUXES];
	logic [31:0] enable_q   [imx_pkg::TAB_MUXES];
	logic [31:0] serviced_q [imx_pkg::TAB_MUXES];
	logic [31:0] live       [imx_pkg::TAB_MUXES];

	logic        sel;
	logic        present;
	logic [7:0]  entry;
	logic [31:0] cur_status, cur_enable, cur_serviced;
	logic [31:0] nxt_status, nxt_enable, nxt_serviced;
	logic [31:0] stuck;
	logic [31:0] src_bit, en_bit;
	logic [1:0]  code;
	logic [1:0]  parent;

	assign sel     = req.item.mux_select;
	assign present = (MUX_COUNT > 1) || !sel;
	assign entry   = imx_pkg::map_entry(sel, req.item.source_bit);

	// live sources: latched and mapped enable set
	always_comb begin
		logic [7:0] e;
		for (int m = 0; m < imx_pkg::TAB_MUXES; m++) begin
			for (int b = 0; b < imx_pkg::WORD_BITS; b++) begin
				e = imx_pkg::ENABLE_MAP[m][b];
				live[m][b] = (m < MUX_COUNT) && (b < SCAN_BITS) && status_q[m][b] &&
					(e < 8'(imx_pkg::WORD_BITS)) && enable_q[m][e[4:0]];
			end
		end
	end

	assign cur_status   = status_q[sel];
	assign cur_enable   = enable_q[sel];
	assign cur_serviced = serviced_q[sel];
	assign stuck        = (present && req.item.command == imx_pkg::CMD_ACK) ?
		(cur_status & cur_serviced) : '0;
	assign src_bit      = 32'd1 << req.item.source_bit;
	assign en_bit       = 32'd1 << entry[4:0];

	always_comb begin
		nxt_status   = cur_status;
		nxt_enable   = cur_enable;
		nxt_serviced = cur_serviced;
		code         = imx_pkg::RC_OK;
		case (req.item.command)
			imx_pkg::CMD_EVENT: begin
				nxt_status = cur_status | req.item.line_levels;
			end
			imx_pkg::CMD_MASK: begin
				nxt_status = cur_status & ~src_bit;
			end
			imx_pkg::CMD_UNMASK, imx_pkg::CMD_DISABLE: begin
				if (!present || entry == imx_pkg::ENT_UNUSED) begin
					code = imx_pkg::RC_UNUSED;
				end else if (entry >= 8'(imx_pkg::WORD_BITS)) begin
					code = imx_pkg::RC_RSVD;
				end else if (req.item.command == imx_pkg::CMD_UNMASK) begin
					nxt_enable = cur_enable | en_bit;
				end else begin
					nxt_enable = cur_enable & ~en_bit;
				end
			end
			imx_pkg::CMD_W1C: begin
				nxt_status = cur_status & ~req.item.write_data;
			end
			imx_pkg::CMD_WR_EN: begin
				nxt_enable = req.item.write_data;
			end
			imx_pkg::CMD_DISPATCH: begin
				nxt_serviced = live[sel];
			end
			imx_pkg::CMD_ACK: begin
				nxt_status   = cur_status & ~stuck;
				nxt_serviced = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < imx_pkg::TAB_MUXES; m++) begin
				status_q[m]   <= '0;
				enable_q[m]   <= '0;
				serviced_q[m] <= '0;
			end
		end else if (req.exec && present) begin
			status_q[sel]   <= nxt_status;
			enable_q[sel]   <= nxt_enable;
			serviced_q[sel] <= nxt_serviced;
		end
	end

	always_comb begin
		for (int m = 0; m < 2; m++) begin
			parent[m] = (m < imx_pkg::TAB_MUXES) ? |live[m] : 1'b0;
		end
	end

	assign rsp.code        = code;
	assign rsp.parent_irq  = parent;
	assign rsp.present     = present;
	assign rsp.stuck       = stuck;
	assign rsp.live_sel    = present ? live[sel] : '0;
	assign rsp.status_word = present ? cur_status : '0;
	assign rsp.enable_word = present ? cur_enable : '0;

endmodule

// ===== rtl/core/imx_ctrl.sv =====
// sequencer: item register, bit-serial dispatch scan and result register
module imx_ctrl #(
	parameter int SOURCES_PER_MUX = imx_pkg::SOURCES_PER_MUX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  imx_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output imx_pkg::out_beat_t out_data,
	output imx_pkg::bank_req_t req,
	input  imx_pkg::bank_rsp_t rsp
);
	localparam int SCAN_BITS = (SOURCES_PER_MUX < imx_pkg::WORD_BITS) ?
		SOURCES_PER_MUX : imx_pkg::WORD_BITS;
	localparam int CNT_W = (SCAN_BITS > 1) ? $clog2(SCAN_BITS) : 1;
	localparam logic [5:0] SRC_BASE = 6'(SOURCES_PER_MUX % 64);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_REPORT = 2'd2;
	localparam logic [1:0] ST_SCAN   = 2'd3;

	logic [1:0]         state_q;
	imx_pkg::in_beat_t  item_q;
	logic [1:0]         code_q;
	logic [31:0]        stuck_q;
	logic [31:0]        served_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	imx_pkg::out_beat_t out_q;

	logic        out_free;
	logic        hit;
	logic [31:0] hit_bit;
	logic [31:0] rest;
	logic        load;
	imx_pkg::out_beat_t beat;

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign hit_bit  = 32'd1 << 5'(cnt_q);
	assign hit      = |(served_q & hit_bit);
	assign rest     = served_q & ~hit_bit;

	assign req.exec = (state_q == ST_EXEC);
	assign req.item = item_q;

	// result beat built from the state after the update
	always_comb begin
		beat.status_word = rsp.status_word;
		beat.enable_word = rsp.enable_word;
		beat.parent_irq  = rsp.parent_irq;
		if (state_q == ST_SCAN) begin
			beat.source_number = (item_q.mux_select ? SRC_BASE : 6'd0) + 6'(cnt_q);
			beat.found         = 1'b1;
			beat.last          = (rest == '0);
			beat.result_code   = imx_pkg::RC_OK;
			beat.stuck_mask    = '0;
		end else begin
			beat.source_number = '0;
			beat.found         = 1'b0;
			beat.last          = 1'b1;
			beat.result_code   = code_q;
			beat.stuck_mask    = stuck_q;
		end
	end

	assign load = out_free && ((state_q == ST_REPORT) || (state_q == ST_SCAN && hit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					cnt_q <= '0;
					if (item_q.command == imx_pkg::CMD_DISPATCH && rsp.live_sel != '0) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_REPORT;
					end
				end
				ST_REPORT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (!hit || out_free) begin
						cnt_q <= cnt_q + 1'b1;
						if (hit && rest == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
		if (state_q == ST_EXEC) begin
			code_q   <= rsp.code;
			stuck_q  <= rsp.stuck;
			served_q <= (item_q.command == imx_pkg::CMD_DISPATCH) ? rsp.live_sel : '0;
		end else if (state_q == ST_SCAN && load) begin
			served_q <= rest;
		end
		if (load) begin
			out_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/core/interrupt_mux_with_mapped_enables.sv =====
// top level of the interrupt mux pair: sequencer plus register bank
// first result beat: after the update, or on dispatch when the scan hits the lowest serviced bit
// other commands, and a dispatch that finds nothing: accept, update, report, then the next item
// dispatch: after the update the scan walks the status bits up to the highest serviced bit,
//   which lies below SOURCES_PER_MUX (capped at 32); a stalled result beat holds the scan
// reset: arst_n clears status, enable and serviced words of every mux and idles the sequencer
module interrupt_mux_with_mapped_enables #(
	parameter int SOURCES_PER_MUX = imx_pkg::SOURCES_PER_MUX_DEF,
	parameter int MUX_COUNT       = imx_pkg::MUX_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  imx_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output imx_pkg::out_beat_t out_data
);
	// request from the sequencer (update strobe plus held item) and bank view back
	imx_pkg::bank_req_t req;
	imx_pkg::bank_rsp_t rsp;

	// sequencer: holds one item, runs update then report, or the dispatch scan
	imx_ctrl #(
		.SOURCES_PER_MUX(SOURCES_PER_MUX)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.req      (req),
		.rsp      (rsp)
	);

	// register bank: w1c status latch, enable word, serviced set, live and parent irq
	imx_bank #(
		.SOURCES_PER_MUX(SOURCES_PER_MUX),
		.MUX_COUNT      (MUX_COUNT)
	) u_bank (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

`ifndef NO_ASSERTIONS
	// one item at a time: ready drops right after an accepted beat
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a beat while busy");

	// a not-found beat closes its item and names no source
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.last && out_data.source_number == 6'd0)
		else $error("not-found beat malformed");

	// dispatched sources carry neither an error code nor a stuck mask
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.found |->
			out_data.result_code == imx_pkg::RC_OK && out_data.stuck_mask == '0)
		else $error("dispatch beat carries code or stuck bits");

	// the sequencer never idles while a new result still has to be produced
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 (out_valid || !in_ready))
		else $error("item produced no result");
`endif

endmodule
